/* rtl/core/lbsd_pkg.sv */
package lbsd_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = 12;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_DIST     = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    localparam logic [4:0] MIN_COPY    = 5'd3;
    localparam logic [1:0] HDR_LAST    = 2'd3;
    localparam logic [3:0] FLAG_COUNT  = 4'd8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [7:0]           data;
        logic [RING_AW-1:0]   src;
        logic [RING_AW-1:0]   dst;
        logic [4:0]           cnt;
        logic                 done;
        logic [1:0]           status;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_WAIT5,
        PH_FLAG,
        PH_ITEM,
        PH_TOKLO
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_COPY_RD,
        B_COPY_WR,
        B_STATUS
    } bstate_t;

endpackage

/* rtl/core/lbsd_ram.sv */
module lbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lbsd_cmd_fifo.sv */
module lbsd_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lbsd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output lbsd_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    lbsd_pkg::cmd_t                entry_reg [lbsd_pkg::FIFO_DEPTH];
    logic [lbsd_pkg::FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lbsd_pkg::FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lbsd_pkg::FIFO_AW:0]    count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (lbsd_pkg::FIFO_AW+1)'(lbsd_pkg::FIFO_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/lbsd_front.sv */
module lbsd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  lbsd_pkg::in_item_t item,
    output logic              push,
    output lbsd_pkg::cmd_t    cmd
);

    lbsd_pkg::phase_t               phase_reg, phase_next, phase_eff;
    logic [31:0]                    rem_reg, rem_next, rem_eff;
    logic [1:0]                     hc_reg, hc_next, hc_eff;
    logic [7:0]                     flags_reg, flags_next, flags_eff;
    logic [3:0]                     left_reg, left_next, left_eff;
    logic [7:0]                     th_reg, th_next;
    logic [lbsd_pkg::RING_AW-1:0]   wptr_reg, wptr_next, wptr_eff;
    logic                           full_reg, full_next, full_eff;

    logic [31:0]                    hdr_val;
    logic [15:0]                    token;
    logic [lbsd_pkg::RING_AW:0]     back_dist;
    logic [4:0]                     cnt;
    logic [lbsd_pkg::RING_AW:0]     wptr_sum;
    logic [31:0]                    cnt_ext;

    // a first byte restarts the resource before the byte itself is decoded
    assign phase_eff = item.first_byte ? lbsd_pkg::PH_HEADER : phase_reg;
    assign rem_eff   = item.first_byte ? '0 : rem_reg;
    assign hc_eff    = item.first_byte ? '0 : hc_reg;
    assign flags_eff = item.first_byte ? '0 : flags_reg;
    assign left_eff  = item.first_byte ? '0 : left_reg;
    assign wptr_eff  = item.first_byte ? '0 : wptr_reg;
    assign full_eff  = item.first_byte ? 1'b0 : full_reg;

    assign hdr_val   = {rem_eff[23:0], item.in_byte};
    assign token     = {th_reg, item.in_byte};
    assign back_dist = {1'b0, token[lbsd_pkg::RING_AW-1:0]} + 1'b1;
    assign cnt       = {1'b0, token[15:12]} + lbsd_pkg::MIN_COPY;
    assign cnt_ext   = 32'(cnt);
    assign wptr_sum  = {1'b0, wptr_eff} + (lbsd_pkg::RING_AW+1)'(cnt);

    always_comb begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        hc_next    = hc_reg;
        flags_next = flags_reg;
        left_next  = left_reg;
        th_next    = th_reg;
        wptr_next  = wptr_reg;
        full_next  = full_reg;
        push       = 1'b0;
        cmd        = '0;
        cmd.kind   = lbsd_pkg::CMD_END;
        cmd.dst    = wptr_eff;
        cmd.data   = item.in_byte;

        if (take) begin
            phase_next = phase_eff;
            rem_next   = rem_eff;
            hc_next    = hc_eff;
            flags_next = flags_eff;
            left_next  = left_eff;
            wptr_next  = wptr_eff;
            full_next  = full_eff;
            if (item.first_byte) begin
                th_next = '0;
            end
            case (phase_eff)
                lbsd_pkg::PH_HEADER: begin
                    rem_next = hdr_val;
                    hc_next  = hc_eff + 1'b1;
                    if (hc_eff == lbsd_pkg::HDR_LAST) begin
                        phase_next = (hdr_val == '0) ? lbsd_pkg::PH_WAIT5 : lbsd_pkg::PH_FLAG;
                    end
                    if (item.final_byte) begin
                        push       = 1'b1;
                        cmd.done   = 1'b1;
                        cmd.status = lbsd_pkg::ST_SHORT;
                        phase_next = lbsd_pkg::PH_IDLE;
                    end
                end
                lbsd_pkg::PH_WAIT5: begin
                    push       = 1'b1;
                    cmd.done   = 1'b1;
                    cmd.status = lbsd_pkg::ST_OK;
                    phase_next = lbsd_pkg::PH_IDLE;
                end
                lbsd_pkg::PH_FLAG: begin
                    flags_next = item.in_byte;
                    left_next  = lbsd_pkg::FLAG_COUNT;
                    phase_next = lbsd_pkg::PH_ITEM;
                    if (item.final_byte) begin
                        push       = 1'b1;
                        cmd.done   = 1'b1;
                        cmd.status = lbsd_pkg::ST_MISMATCH;
                        phase_next = lbsd_pkg::PH_IDLE;
                    end
                end
                lbsd_pkg::PH_ITEM: begin
                    flags_next = {1'b0, flags_eff[7:1]};
                    left_next  = left_eff - 1'b1;
                    if (flags_eff[0]) begin
                        th_next    = item.in_byte;
                        phase_next = lbsd_pkg::PH_TOKLO;
                        if (item.final_byte) begin
                            push       = 1'b1;
                            cmd.done   = 1'b1;
                            cmd.status = lbsd_pkg::ST_MISMATCH;
                            phase_next = lbsd_pkg::PH_IDLE;
                        end
                    end else begin
                        push      = 1'b1;
                        cmd.kind  = lbsd_pkg::CMD_LIT;
                        wptr_next = wptr_eff + 1'b1;
                        full_next = full_eff | (wptr_eff == '1);
                        rem_next  = rem_eff - 1'b1;
                        if (rem_eff == 32'd1) begin
                            cmd.done   = 1'b1;
                            cmd.status = lbsd_pkg::ST_OK;
                            phase_next = lbsd_pkg::PH_IDLE;
                        end else begin
                            phase_next = (left_next == '0) ? lbsd_pkg::PH_FLAG
                                                           : lbsd_pkg::PH_ITEM;
                            if (item.final_byte) begin
                                cmd.done   = 1'b1;
                                cmd.status = lbsd_pkg::ST_MISMATCH;
                                phase_next = lbsd_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                lbsd_pkg::PH_TOKLO: begin
                    push = 1'b1;
                    // history holds min(bytes_out, ring size) valid bytes
                    if (!full_eff && (back_dist > {1'b0, wptr_eff})) begin
                        cmd.done   = 1'b1;
                        cmd.status = lbsd_pkg::ST_DIST;
                        phase_next = lbsd_pkg::PH_IDLE;
                    end else begin
                        cmd.kind  = lbsd_pkg::CMD_COPY;
                        cmd.src   = wptr_eff - back_dist[lbsd_pkg::RING_AW-1:0];
                        cmd.cnt   = cnt;
                        wptr_next = wptr_sum[lbsd_pkg::RING_AW-1:0];
                        full_next = full_eff | wptr_sum[lbsd_pkg::RING_AW];
                        rem_next  = rem_eff - cnt_ext;
                        if (rem_eff == cnt_ext) begin
                            cmd.done   = 1'b1;
                            cmd.status = lbsd_pkg::ST_OK;
                            phase_next = lbsd_pkg::PH_IDLE;
                        end else if (rem_eff < cnt_ext) begin
                            cmd.done   = 1'b1;
                            cmd.status = lbsd_pkg::ST_MISMATCH;
                            phase_next = lbsd_pkg::PH_IDLE;
                        end else begin
                            phase_next = (left_eff == '0) ? lbsd_pkg::PH_FLAG
                                                          : lbsd_pkg::PH_ITEM;
                            if (item.final_byte) begin
                                cmd.done   = 1'b1;
                                cmd.status = lbsd_pkg::ST_MISMATCH;
                                phase_next = lbsd_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                lbsd_pkg::PH_IDLE: begin
                    phase_next = lbsd_pkg::PH_IDLE;
                end
                default: begin
                    phase_next = lbsd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lbsd_pkg::PH_IDLE;
            rem_reg   <= '0;
            hc_reg    <= '0;
            flags_reg <= '0;
            left_reg  <= '0;
            th_reg    <= '0;
            wptr_reg  <= '0;
            full_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            hc_reg    <= hc_next;
            flags_reg <= flags_next;
            left_reg  <= left_next;
            th_reg    <= th_next;
            wptr_reg  <= wptr_next;
            full_reg  <= full_next;
        end
    end

endmodule

/* rtl/core/lbsd_back.sv */
module lbsd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lbsd_pkg::cmd_t                head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          ram_we,
    output logic [lbsd_pkg::RING_AW-1:0]  ram_waddr,
    output logic [7:0]                    ram_wdata,
    output logic [lbsd_pkg::RING_AW-1:0]  ram_raddr,
    input  logic [7:0]                    ram_rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lbsd_pkg::out_item_t           m_item
);

    lbsd_pkg::bstate_t              state_reg, state_next;
    logic [lbsd_pkg::RING_AW-1:0]   src_reg, src_next;
    logic [lbsd_pkg::RING_AW-1:0]   dst_reg, dst_next;
    logic [4:0]                     cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [1:0]                     status_reg, status_next;
    logic                           fwd_reg, fwd_next;
    logic [7:0]                     last_reg, last_next;
    logic                           m_valid_reg, m_valid_next;
    lbsd_pkg::out_item_t            m_item_reg, m_item_next;

    logic                           slot_free;
    logic [7:0]                     byte_sel;

    assign slot_free = !m_valid_reg || m_ready;
    // distance one reads the byte written in the same cycle
    assign byte_sel  = fwd_reg ? last_reg : ram_rdata;

    always_comb begin
        state_next   = state_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        cnt_next     = cnt_reg;
        done_next    = done_reg;
        status_next  = status_reg;
        fwd_next     = fwd_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = dst_reg;
        ram_wdata    = byte_sel;
        ram_raddr    = src_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        case (state_reg)
            lbsd_pkg::B_IDLE: begin
                if (!empty) begin
                    case (head.kind)
                        lbsd_pkg::CMD_LIT: begin
                            if (slot_free) begin
                                pop          = 1'b1;
                                ram_we       = 1'b1;
                                ram_waddr    = head.dst;
                                ram_wdata    = head.data;
                                m_valid_next = 1'b1;
                                m_item_next  = '{out_byte: head.data, byte_valid: 1'b1,
                                                 done_res: 1'b0, status: lbsd_pkg::ST_OK};
                                status_next  = head.status;
                                if (head.done) begin
                                    state_next = lbsd_pkg::B_STATUS;
                                end
                            end
                        end
                        lbsd_pkg::CMD_COPY: begin
                            pop         = 1'b1;
                            src_next    = head.src;
                            dst_next    = head.dst;
                            cnt_next    = head.cnt;
                            done_next   = head.done;
                            status_next = head.status;
                            fwd_next    = 1'b0;
                            state_next  = lbsd_pkg::B_COPY_RD;
                        end
                        lbsd_pkg::CMD_END: begin
                            if (slot_free) begin
                                pop          = 1'b1;
                                m_valid_next = 1'b1;
                                m_item_next  = '{out_byte: 8'd0, byte_valid: 1'b0,
                                                 done_res: 1'b1, status: head.status};
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            lbsd_pkg::B_COPY_RD: begin
                state_next = lbsd_pkg::B_COPY_WR;
            end
            lbsd_pkg::B_COPY_WR: begin
                if (slot_free) begin
                    ram_we       = 1'b1;
                    ram_raddr    = src_reg + 1'b1;
                    m_valid_next = 1'b1;
                    m_item_next  = '{out_byte: byte_sel, byte_valid: 1'b1,
                                     done_res: 1'b0, status: lbsd_pkg::ST_OK};
                    src_next     = src_reg + 1'b1;
                    dst_next     = dst_reg + 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    fwd_next     = ((src_reg + 1'b1) == dst_reg);
                    last_next    = byte_sel;
                    if (cnt_reg == 5'd1) begin
                        state_next = done_reg ? lbsd_pkg::B_STATUS : lbsd_pkg::B_IDLE;
                    end
                end
            end
            lbsd_pkg::B_STATUS: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{out_byte: 8'd0, byte_valid: 1'b0,
                                     done_res: 1'b1, status: status_reg};
                    state_next   = lbsd_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = lbsd_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lbsd_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            fwd_reg     <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        cnt_reg    <= cnt_next;
        done_reg   <= done_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* rtl/core/lzss_byte_stream_decoder.sv */
// LZSS decoder with a 4096-byte history window. Bytes of a compressed resource go in one per
// item (first_byte restarts, final_byte marks the end); every decompressed byte comes out as
// its own result and each resource ends with one status-only result that has done_res set.
// The front end takes one input byte per cycle while its four-entry command queue has room
// and turns the bytes into literal, match and end commands. The back end runs the history
// RAM: a literal is written and emitted as it is popped; a match of n bytes (3 to 18)
// is popped, given one lead-in read, then has one byte read, written and emitted per cycle
// while the output register is free; a final status result follows. Sustained rate is
// therefore set by the back end's single RAM write port, and is lowest for an input byte
// whose 18-byte match also ends the resource. No clearing pass is needed after reset.
module lzss_byte_stream_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lbsd_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output lbsd_pkg::out_item_t m_item
);

    logic                          take;
    logic                          push;
    lbsd_pkg::cmd_t                push_cmd;
    logic                          pop;
    lbsd_pkg::cmd_t                head;
    logic                          empty;
    logic                          full;
    logic                          ram_we;
    logic [lbsd_pkg::RING_AW-1:0]  ram_waddr;
    logic [7:0]                    ram_wdata;
    logic [lbsd_pkg::RING_AW-1:0]  ram_raddr;
    logic [7:0]                    ram_rdata;

    assign s_ready = !full;
    assign take    = s_valid && s_ready;

    lbsd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (s_item),
        .push    (push),
        .cmd     (push_cmd)
    );

    lbsd_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    lbsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    lbsd_ram #(
        .WIDTH (8),
        .DEPTH (lbsd_pkg::RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // every history write is a data byte leaving through the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (m_valid && m_item.byte_valid))
        else $error("history write without a data result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command pushed into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command popped from an empty queue");

endmodule

/* sim/lzss_decode_checker.sv */
module lzss_decode_checker
    import lbsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        mismatches,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  window [RING_DEPTH];
    logic [31:0] out_count;
    logic [31:0] want_len;
    logic [2:0]  hdr_seen;
    logic [7:0]  flags;
    logic [3:0]  flags_left;
    logic [7:0]  tok_hi;
    phase_t      phase;
    out_item_t   expected_results[$];

    task automatic end_resource(input logic [1:0] st);
        out_item_t r;
        r = '{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1, status: st};
        expected_results = {expected_results, r};
        phase = PH_IDLE;
    endtask

    task automatic emit_data(input logic [7:0] b);
        out_item_t r;
        window[out_count[RING_AW-1:0]] = b;
        out_count = out_count + 32'd1;
        r = '{out_byte: b, byte_valid: 1'b1, done_res: 1'b0, status: ST_OK};
        expected_results = {expected_results, r};
    endtask

    task automatic decode_input_byte(input in_item_t it);
        logic [7:0]  b;
        logic [31:0] remaining;
        logic [31:0] produced;
        logic        item_done;
        logic        is_token;
        logic [15:0] token;
        logic [12:0] back_dist;
        logic [4:0]  cnt;
        logic [31:0] src;
        int          i;
        b = it.in_byte;
        produced = 32'd0;
        item_done = 1'b0;
        if (it.first_byte) begin
            out_count = '0;
            want_len = '0;
            hdr_seen = '0;
            flags = '0;
            flags_left = '0;
            tok_hi = '0;
            phase = PH_HEADER;
        end else if (phase == PH_IDLE) begin
            return;
        end
        remaining = want_len - out_count;
        case (phase)
            PH_HEADER: begin
                want_len = {want_len[23:0], b};
                hdr_seen = hdr_seen + 3'd1;
                if (hdr_seen >= 3'd4)
                    phase = (want_len == 32'd0) ? PH_WAIT5 : PH_FLAG;
                if (it.final_byte)
                    end_resource(ST_SHORT);
                return;
            end
            PH_WAIT5: begin
                end_resource(ST_OK);
                return;
            end
            PH_FLAG: begin
                flags = b;
                flags_left = FLAG_COUNT;
                phase = PH_ITEM;
            end
            PH_ITEM: begin
                is_token = flags[0];
                flags = flags >> 1;
                flags_left = flags_left - 4'd1;
                if (is_token) begin
                    tok_hi = b;
                    phase = PH_TOKLO;
                end else begin
                    emit_data(b);
                    produced = 32'd1;
                    item_done = 1'b1;
                end
            end
            PH_TOKLO: begin
                token = {tok_hi, b};
                back_dist = token[11:0] + 13'd1;
                cnt = token[15:12] + MIN_COPY;
                if (back_dist > out_count) begin
                    end_resource(ST_DIST);
                    return;
                end
                for (i = 0; i < cnt; i++) begin
                    src = out_count - back_dist;
                    emit_data(window[src[RING_AW-1:0]]);
                end
                produced = 32'(cnt);
                item_done = 1'b1;
            end
            default: begin
                phase = PH_IDLE;
                return;
            end
        endcase
        if (item_done) begin
            if (produced == remaining) begin
                end_resource(ST_OK);
                return;
            end
            if (produced > remaining) begin
                end_resource(ST_MISMATCH);
                return;
            end
            phase = (flags_left == 4'd0) ? PH_FLAG : PH_ITEM;
        end
        if (it.final_byte && phase != PH_IDLE)
            end_resource(ST_MISMATCH);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            out_count = '0;
            want_len = '0;
            hdr_seen = '0;
            flags = '0;
            flags_left = '0;
            tok_hi = '0;
            phase = PH_IDLE;
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("extra result: out_byte %0d valid %0d done %0d status %0d",
                           m_item.out_byte, m_item.byte_valid, m_item.done_res, m_item.status);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("out_byte", want.out_byte, m_item.out_byte);
                    check_field("byte_valid", want.byte_valid, m_item.byte_valid);
                    check_field("done_res", want.done_res, m_item.done_res);
                    check_field("status", want.status, m_item.status);
                end
            end
            if (s_valid && s_ready)
                decode_input_byte(s_item);
        end
        outstanding = expected_results.size();
    end

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbsd_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int        failures;
    int        outstanding;
    int        sender_idle_pct = 0;
    int        receiver_idle_pct = 0;
    int        rand_items = 0;
    bit        stall_req = 1'b0;
    int        stall_left = 0;
    byte_q_t   body;
    int unsigned body_len;

    lzss_byte_stream_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    lzss_decode_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .mismatches  (failures),
        .outstanding (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver: random back-pressure, plus a long hold-off on each request
    initial forever begin
        @(negedge aclk);
        if (stall_req) begin
            stall_left = 300;
            stall_req = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial begin
        #2ms;
        $display("testbench: FAIL");
        $finish;
    end

    // called and returns at a falling edge
    task automatic offer(input logic [7:0] b, input logic first, input logic fin);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= '{in_byte: b, first_byte: first, final_byte: fin};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_stream(input byte_q_t q, input bit fin_last, input bit counted);
        for (int i = 0; i < q.size(); i++) begin
            offer(q[i], i == 0, fin_last && (i == q.size() - 1));
            if (counted)
                rand_items++;
        end
    endtask

    // compressed body of n items; with bad_dist one match reaches past the output so far
    task automatic make_body(input int n_items, input bit bad_dist);
        byte_q_t     group;
        logic [7:0]  flag;
        logic [15:0] token;
        int unsigned made;
        int unsigned back_dist;
        int unsigned cnt;
        int          bad_at;
        int          k;
        int          j;
        body = {};
        made = 0;
        k = 0;
        bad_at = bad_dist ? $urandom_range(0, n_items - 1) : -1;
        while (k < n_items) begin
            group = {};
            flag = 8'h00;
            for (j = 0; j < 8 && k < n_items; j++) begin
                if (k == bad_at || (made > 0 && $urandom_range(0, 1) == 1)) begin
                    if (k == bad_at)
                        back_dist = $urandom_range(made + 1, RING_DEPTH);
                    else
                        back_dist = $urandom_range(1, made);
                    cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 18)
                                                       : $urandom_range(3, 6);
                    token[15:12] = 4'(cnt - 3);
                    token[11:0] = 12'(back_dist - 1);
                    group = {group, token[15:8], token[7:0]};
                    flag[j] = 1'b1;
                    made += cnt;
                end else begin
                    group = {group, 8'($urandom_range(0, 255))};
                    made++;
                end
                k++;
            end
            body = {body, flag, group};
        end
        body_len = made;
    endtask

    initial begin : stimulus
        byte_q_t     stream;
        logic [31:0] len;
        int          kind;
        int          cut;
        bit          stalled_late;
        stalled_late = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // idle decoder ignores stray bytes
        offer(8'h3c, 1'b0, 1'b1);
        // four header bytes and nothing else
        send_stream('{8'h00, 8'h00, 8'h00, 8'h07}, 1'b1, 1'b0);
        // zero length ends on the fifth byte; the byte after it is ignored
        send_stream('{8'h00, 8'h00, 8'h00, 8'h00, 8'haa}, 1'b1, 1'b0);
        offer(8'h55, 1'b0, 1'b0);
        // literals 0xff, 0x00, then an 18-byte match that runs past the length
        send_stream('{8'h00, 8'h00, 8'h00, 8'h13, 8'h04, 8'hff, 8'h00, 8'hf0, 8'h00},
                    1'b0, 1'b0);
        // distance 4096 after a single byte
        send_stream('{8'h00, 8'h00, 8'h00, 8'h05, 8'h02, 8'h5a, 8'h0f, 8'hff}, 1'b1, 1'b0);

        stall_req = 1'b1;
        while (rand_items < 140) begin
            if (rand_items < 47) begin
                sender_idle_pct = 23;
                receiver_idle_pct = 69;
            end else if (rand_items < 94) begin
                sender_idle_pct = 69;
                receiver_idle_pct = 23;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
                if (!stalled_late) begin
                    stalled_late = 1'b1;
                    stall_req = 1'b1;
                end
            end
            kind = $urandom_range(0, 99);
            if (kind >= 92) begin
                // noise
                repeat ($urandom_range(1, 4)) begin
                    offer(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                          1'($urandom_range(0, 1)));
                    rand_items++;
                end
            end else if (kind >= 84) begin
                stream = {};
                if ($urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(1, 4))
                        stream = {stream, 8'($urandom_range(0, 255))};
                end else begin
                    stream = '{8'h00, 8'h00, 8'h00, 8'h00};
                    repeat ($urandom_range(1, 3))
                        stream = {stream, 8'($urandom_range(0, 255))};
                end
                send_stream(stream, 1'b1, 1'b1);
            end else begin
                make_body($urandom_range(1, 10), kind >= 76);
                len = body_len;
                if (kind >= 40 && kind < 50 && body_len > 1)
                    len = $urandom_range(1, body_len - 1);
                else if (kind >= 50 && kind < 58)
                    len = ($urandom_range(0, 3) == 0) ? $urandom
                                                      : body_len + $urandom_range(1, 5);
                stream = '{len[31:24], len[23:16], len[15:8], len[7:0]};
                stream = {stream, body};
                if (kind >= 58 && kind < 76 && stream.size() > 5) begin
                    // truncated resource, or abandoned by the next first byte
                    cut = $urandom_range(5, stream.size() - 1);
                    stream = stream[0:cut-1];
                    send_stream(stream, kind < 67, 1'b1);
                end else begin
                    send_stream(stream, 1'b1, 1'b1);
                end
            end
        end
        s_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
